// ===== rtl/cau_pkg.sv =====
// ----------------------------------------------------------------------------
// cau_pkg: shared types and constants of the complex arithmetic unit
// Operation codes, status codes, the CORDIC angle table, the per-stage
// iteration record and the signed 32-bit saturation helper.
// ----------------------------------------------------------------------------
package cau_pkg;

    typedef enum logic [2:0] {
        MODE_ADD  = 3'd0,
        MODE_SUB  = 3'd1,
        MODE_MUL  = 3'd2,
        MODE_DIV  = 3'd3,
        MODE_CONJ = 3'd4,
        MODE_NEG  = 3'd5,
        MODE_MAG  = 3'd6,
        MODE_ARG  = 3'd7
    } t_mode;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_DZ  = 2'd1;
    localparam logic [1:0] ST_SAT = 2'd2;

    // quotient bits per division, square root steps, iteration stages
    localparam int QBITS    = 33;
    localparam int SQ_STEPS = 32;
    localparam int NIT      = 33;

    localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;

    localparam logic signed [31:0] ATAN_Q30 [0:31] = '{
        32'sd843314857, 32'sd497837829, 32'sd263043837, 32'sd133525159,
        32'sd67021687,  32'sd33543516,  32'sd16775851,  32'sd8388437,
        32'sd4194283,   32'sd2097149,   32'sd1048576,   32'sd524288,
        32'sd262144,    32'sd131072,    32'sd65536,     32'sd32768,
        32'sd16384,     32'sd8192,      32'sd4096,      32'sd2048,
        32'sd1024,      32'sd512,       32'sd256,       32'sd128,
        32'sd64,        32'sd32,        32'sd16,        32'sd8,
        32'sd4,         32'sd2,         32'sd1,         32'sd0
    };

    typedef struct packed {
        logic [31:0] val;
        logic        sat;
    } t_sat;

    // one lane of the restoring divider
    typedef struct packed {
        logic        neg;
        logic        ovf;
        logic [63:0] rem;
        logic [32:0] low;
        logic [32:0] q;
    } t_lane;

    typedef struct packed {
        t_mode              mode;
        logic [31:0]        rr;
        logic [31:0]        ri;
        logic               sat;
        logic               spec;
        logic               dz;
        logic [63:0]        d;
        t_lane              lre;
        t_lane              lim;
        logic [63:0]        sv;
        logic [33:0]        srem;
        logic [31:0]        root;
        logic signed [35:0] cx;
        logic signed [35:0] cy;
        logic signed [31:0] cz;
    } t_it;

    // clamp a sign and magnitude pair to the signed 32-bit range
    function automatic t_sat f_sat32(input logic neg, input logic [63:0] mag);
        t_sat r;
        r.sat = 1'b0;
        r.val = neg ? (~mag[31:0] + 32'd1) : mag[31:0];
        if (!neg && mag > 64'h7FFF_FFFF) begin
            r.val = 32'h7FFF_FFFF;
            r.sat = 1'b1;
        end else if (neg && mag > 64'h8000_0000) begin
            r.val = 32'h8000_0000;
            r.sat = 1'b1;
        end
        return r;
    endfunction

endpackage

// ===== rtl/cau_front.sv =====
// ----------------------------------------------------------------------------
// cau_front: operand capture, products and iteration setup
// Four register stages: input capture, partial products and simple results,
// signed sums of products, divider / root / CORDIC start values.
// ----------------------------------------------------------------------------
module cau_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [2:0]         i_mode,
    input  logic signed [31:0] i_a_real,
    input  logic signed [31:0] i_a_imag,
    input  logic signed [31:0] i_b_real,
    input  logic signed [31:0] i_b_imag,
    output logic               o_valid,
    output cau_pkg::t_it       o_it
);

    localparam int SH = 30 - FRAC_BITS;
    localparam logic [63:0] HP_RND =
        (64'(cau_pkg::HALF_PI_Q30) + (64'd1 << (SH - 1))) >> SH;
    localparam logic [31:0] HP_ANG = HP_RND[31:0];

    typedef struct packed {
        logic        neg;
        logic [63:0] mag;
    } t_smag;

    typedef struct packed {
        cau_pkg::t_mode     mode;
        logic signed [31:0] ar;
        logic signed [31:0] ai;
        logic signed [31:0] br;
        logic signed [31:0] bi;
    } t_f1;

    typedef struct packed {
        cau_pkg::t_mode     mode;
        logic [63:0]        p0;
        logic [63:0]        p1;
        logic [63:0]        p2;
        logic [63:0]        p3;
        logic [63:0]        p4;
        logic [63:0]        p5;
        logic [3:0]         pneg;
        logic [31:0]        rr;
        logic [31:0]        ri;
        logic               sat;
        logic               spec;
        logic signed [35:0] cx;
        logic signed [35:0] cy;
    } t_f2;

    typedef struct packed {
        cau_pkg::t_mode     mode;
        logic [31:0]        rr;
        logic [31:0]        ri;
        logic               sat;
        logic               spec;
        logic signed [35:0] cx;
        logic signed [35:0] cy;
        t_smag              nre;
        t_smag              nim;
        logic [63:0]        d;
        logic [63:0]        v;
    } t_f3;

    function automatic logic [31:0] f_abs(input logic signed [31:0] x);
        return x[31] ? (~x + 32'd1) : x;
    endfunction

    function automatic logic f_pneg(input logic signed [31:0] x, input logic signed [31:0] y);
        return (x != 32'sd0) && (y != 32'sd0) && (x[31] ^ y[31]);
    endfunction

    function automatic cau_pkg::t_sat f_sat33(input logic [32:0] v);
        cau_pkg::t_sat r;
        r.val = v[31:0];
        r.sat = 1'b0;
        if (v[32] != v[31]) begin
            r.val = v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            r.sat = 1'b1;
        end
        return r;
    endfunction

    function automatic t_smag f_sneg(input t_smag a);
        t_smag r;
        r.mag = a.mag;
        r.neg = !a.neg && (a.mag != 64'd0);
        return r;
    endfunction

    function automatic t_smag f_sadd(input t_smag a, input t_smag b);
        t_smag r;
        if (a.neg == b.neg) begin
            r.neg = a.neg;
            r.mag = a.mag + b.mag;
        end else if (a.mag >= b.mag) begin
            r.neg = a.neg;
            r.mag = a.mag - b.mag;
        end else begin
            r.neg = b.neg;
            r.mag = b.mag - a.mag;
        end
        if (r.mag == 64'd0) r.neg = 1'b0;
        return r;
    endfunction

    function automatic cau_pkg::t_lane f_lane(input t_smag n, input logic [63:0] d);
        cau_pkg::t_lane l;
        l.neg = n.neg;
        l.rem = n.mag >> (33 - FRAC_BITS);
        l.ovf = (l.rem >= d);
        l.low = 33'(n.mag << FRAC_BITS);
        l.q   = '0;
        return l;
    endfunction

    logic               r_v1, r_v2, r_v3;
    t_f1                r_f1;
    t_f2                r_f2, n_f2;
    t_f3                r_f3, n_f3;
    cau_pkg::t_it       r_it, n_it;

    logic [31:0]        a_ar, a_ai, a_br, a_bi;
    logic               is_mag, is_mul;
    cau_pkg::t_sat      s_re, s_im, m_re, m_im;
    logic [32:0]        nx, limu;
    logic signed [32:0] ny;
    t_smag              q0, q1, q2, q3;

    // stage 2: products, simple results, CORDIC prenormalization
    always_comb begin
        a_ar   = f_abs(r_f1.ar);
        a_ai   = f_abs(r_f1.ai);
        a_br   = f_abs(r_f1.br);
        a_bi   = f_abs(r_f1.bi);
        is_mag = (r_f1.mode == cau_pkg::MODE_MAG);

        n_f2.mode = r_f1.mode;
        n_f2.p0   = a_ar * (is_mag ? a_ar : a_br);
        n_f2.p1   = a_ai * (is_mag ? a_ai : a_bi);
        n_f2.p2   = a_ai * a_br;
        n_f2.p3   = a_ar * a_bi;
        n_f2.p4   = a_br * a_br;
        n_f2.p5   = a_bi * a_bi;
        n_f2.pneg = {f_pneg(r_f1.ar, r_f1.bi), f_pneg(r_f1.ai, r_f1.br),
                     f_pneg(r_f1.ai, r_f1.bi), f_pneg(r_f1.ar, r_f1.br)};

        s_re = '0;
        s_im = '0;
        n_f2.spec = 1'b0;
        unique case (r_f1.mode)
            cau_pkg::MODE_ADD: begin
                s_re = f_sat33({r_f1.ar[31], r_f1.ar} + {r_f1.br[31], r_f1.br});
                s_im = f_sat33({r_f1.ai[31], r_f1.ai} + {r_f1.bi[31], r_f1.bi});
            end
            cau_pkg::MODE_SUB: begin
                s_re = f_sat33({r_f1.ar[31], r_f1.ar} - {r_f1.br[31], r_f1.br});
                s_im = f_sat33({r_f1.ai[31], r_f1.ai} - {r_f1.bi[31], r_f1.bi});
            end
            cau_pkg::MODE_CONJ: begin
                s_re.val = r_f1.ar;
                s_im = f_sat33(33'd0 - {r_f1.ai[31], r_f1.ai});
            end
            cau_pkg::MODE_NEG: begin
                s_re = f_sat33(33'd0 - {r_f1.ar[31], r_f1.ar});
                s_im = f_sat33(33'd0 - {r_f1.ai[31], r_f1.ai});
            end
            cau_pkg::MODE_ARG: begin
                // on the imaginary axis the angle is fixed
                n_f2.spec = (r_f1.ar == 32'sd0);
                if (r_f1.ai[31])              s_re.val = ~HP_ANG + 32'd1;
                else if (r_f1.ai != 32'sd0)   s_re.val = HP_ANG;
            end
            cau_pkg::MODE_MUL, cau_pkg::MODE_DIV, cau_pkg::MODE_MAG: begin
                s_re = '0;
            end
        endcase
        n_f2.rr  = s_re.val;
        n_f2.ri  = s_im.val;
        n_f2.sat = s_re.sat | s_im.sat;

        // shift up until x or |y| reaches 2^30, binary search by 16,8,4,2,1
        nx = {1'b0, a_ar};
        ny = r_f1.ar[31] ? (33'sd0 - {r_f1.ai[31], r_f1.ai}) : {r_f1.ai[31], r_f1.ai};
        limu = '0;
        for (int j = 4; j >= 0; j--) begin
            limu = 33'd1 << (31 - (1 << j));
            if (nx < limu && ny < $signed(limu) && ny > -$signed(limu)) begin
                nx = nx << (1 << j);
                ny = ny <<< (1 << j);
            end
        end
        n_f2.cx = {3'b000, nx};
        n_f2.cy = {{3{ny[32]}}, ny};
    end

    // stage 3: signed sums of the partial products
    always_comb begin
        is_mul = (r_f2.mode == cau_pkg::MODE_MUL);
        q0 = '{neg: r_f2.pneg[0], mag: r_f2.p0};
        q1 = '{neg: r_f2.pneg[1], mag: r_f2.p1};
        q2 = '{neg: r_f2.pneg[2], mag: r_f2.p2};
        q3 = '{neg: r_f2.pneg[3], mag: r_f2.p3};
        n_f3.mode = r_f2.mode;
        n_f3.rr   = r_f2.rr;
        n_f3.ri   = r_f2.ri;
        n_f3.sat  = r_f2.sat;
        n_f3.spec = r_f2.spec;
        n_f3.cx   = r_f2.cx;
        n_f3.cy   = r_f2.cy;
        n_f3.nre  = f_sadd(q0, is_mul ? f_sneg(q1) : q1);
        n_f3.nim  = f_sadd(q2, is_mul ? q3 : f_sneg(q3));
        n_f3.d    = r_f2.p4 + r_f2.p5;
        n_f3.v    = r_f2.p0 + r_f2.p1;
    end

    // stage 4: product result, divider and root start values
    always_comb begin
        m_re = cau_pkg::f_sat32(r_f3.nre.neg, r_f3.nre.mag >> FRAC_BITS);
        m_im = cau_pkg::f_sat32(r_f3.nim.neg, r_f3.nim.mag >> FRAC_BITS);
        n_it.mode = r_f3.mode;
        n_it.rr   = r_f3.rr;
        n_it.ri   = r_f3.ri;
        n_it.sat  = r_f3.sat;
        if (r_f3.mode == cau_pkg::MODE_MUL) begin
            n_it.rr  = m_re.val;
            n_it.ri  = m_im.val;
            n_it.sat = m_re.sat | m_im.sat;
        end
        n_it.spec = r_f3.spec;
        n_it.dz   = (r_f3.d == 64'd0);
        n_it.d    = r_f3.d;
        n_it.lre  = f_lane(r_f3.nre, r_f3.d);
        n_it.lim  = f_lane(r_f3.nim, r_f3.d);
        n_it.sv   = r_f3.v;
        n_it.srem = '0;
        n_it.root = '0;
        n_it.cx   = r_f3.cx;
        n_it.cy   = r_f3.cy;
        n_it.cz   = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_en) begin
            r_v1    <= i_valid;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            o_valid <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f1 <= '{mode: cau_pkg::t_mode'(i_mode), ar: i_a_real, ai: i_a_imag,
                      br: i_b_real, bi: i_b_imag};
            r_f2 <= n_f2;
            r_f3 <= n_f3;
            r_it <= n_it;
        end
    end

    assign o_it = r_it;

endmodule

// ===== rtl/cau_iter.sv =====
// ----------------------------------------------------------------------------
// cau_iter: one iteration stage
// One quotient bit for each divider lane, one square root digit and one
// CORDIC vectoring rotation, each where this stage lies in its range.
// ----------------------------------------------------------------------------
module cau_iter #(
    parameter int STEP         = 0,
    parameter int CORDIC_STEPS = 24
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic         i_valid,
    input  cau_pkg::t_it i_it,
    output logic         o_valid,
    output cau_pkg::t_it o_it
);

    localparam int AIDX = (STEP < 32) ? STEP : 31;

    function automatic cau_pkg::t_lane f_dstep(input cau_pkg::t_lane l, input logic [63:0] d);
        cau_pkg::t_lane r;
        logic [64:0]    r2;
        logic           qb;
        r2    = {l.rem, l.low[32]};
        qb    = (r2 >= {1'b0, d});
        r     = l;
        r.rem = qb ? 64'(r2 - {1'b0, d}) : r2[63:0];
        r.low = {l.low[31:0], 1'b0};
        r.q   = {l.q[31:0], qb};
        return r;
    endfunction

    cau_pkg::t_it       n_it, r_it;
    logic [35:0]        r2s, trial;
    logic signed [35:0] dx, dy;

    always_comb begin
        n_it     = i_it;
        n_it.lre = f_dstep(i_it.lre, i_it.d);
        n_it.lim = f_dstep(i_it.lim, i_it.d);

        r2s   = {i_it.srem, i_it.sv[63:62]};
        trial = {2'b00, i_it.root, 2'b01};
        if (STEP < cau_pkg::SQ_STEPS) begin
            n_it.sv = {i_it.sv[61:0], 2'b00};
            if (r2s >= trial) begin
                n_it.srem = 34'(r2s - trial);
                n_it.root = {i_it.root[30:0], 1'b1};
            end else begin
                n_it.srem = r2s[33:0];
                n_it.root = {i_it.root[30:0], 1'b0};
            end
        end

        // rotate toward the positive real axis
        dx = i_it.cy >>> STEP;
        dy = i_it.cx >>> STEP;
        if (STEP < CORDIC_STEPS) begin
            if (!i_it.cy[35]) begin
                n_it.cx = i_it.cx + dx;
                n_it.cy = i_it.cy - dy;
                n_it.cz = i_it.cz + cau_pkg::ATAN_Q30[AIDX];
            end else begin
                n_it.cx = i_it.cx - dx;
                n_it.cy = i_it.cy + dy;
                n_it.cz = i_it.cz - cau_pkg::ATAN_Q30[AIDX];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_it <= n_it;
        end
    end

    assign o_it = r_it;

endmodule

// ===== rtl/cau_back.sv =====
// ----------------------------------------------------------------------------
// cau_back: result formatting and output buffering
// Select and saturate the result per operation, then hold it in an output
// register backed by a one-entry skid register.
// ----------------------------------------------------------------------------
module cau_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  cau_pkg::t_it       i_it,
    input  logic               i_stall,
    output logic               o_skid,
    output logic               o_valid,
    output logic signed [31:0] o_res_real,
    output logic signed [31:0] o_res_imag,
    output logic [1:0]         o_status
);

    localparam int SH = 30 - FRAC_BITS;

    typedef struct packed {
        logic [31:0] rr;
        logic [31:0] ri;
        logic [1:0]  st;
    } t_res;

    t_res          n_b, r_b, r_skid, r_out;
    logic          r_bv, r_skid_v, en, out_free;
    cau_pkg::t_sat d_re, d_im, g_mag;
    logic [32:0]   az, am;

    assign en = !r_skid_v;

    always_comb begin
        d_re  = i_it.lre.ovf ? cau_pkg::f_sat32(i_it.lre.neg, 64'hFF_FFFF_FFFF)
                             : cau_pkg::f_sat32(i_it.lre.neg, {31'd0, i_it.lre.q});
        d_im  = i_it.lim.ovf ? cau_pkg::f_sat32(i_it.lim.neg, 64'hFF_FFFF_FFFF)
                             : cau_pkg::f_sat32(i_it.lim.neg, {31'd0, i_it.lim.q});
        g_mag = cau_pkg::f_sat32(1'b0, {32'd0, i_it.root});
        az    = i_it.cz[31] ? (33'd0 - {i_it.cz[31], i_it.cz}) : {i_it.cz[31], i_it.cz};
        am    = (az + (33'd1 << (SH - 1))) >> SH;

        n_b.rr = i_it.rr;
        n_b.ri = i_it.ri;
        n_b.st = i_it.sat ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
        unique case (i_it.mode)
            cau_pkg::MODE_DIV: begin
                if (i_it.dz) begin
                    n_b = '{rr: 32'd0, ri: 32'd0, st: cau_pkg::ST_DZ};
                end else begin
                    n_b.rr = d_re.val;
                    n_b.ri = d_im.val;
                    n_b.st = (d_re.sat | d_im.sat) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
                end
            end
            cau_pkg::MODE_MAG: begin
                n_b.rr = g_mag.val;
                n_b.ri = 32'd0;
                n_b.st = g_mag.sat ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
            end
            cau_pkg::MODE_ARG: begin
                if (!i_it.spec) n_b.rr = i_it.cz[31] ? 32'(33'd0 - am) : am[31:0];
                n_b.ri = 32'd0;
                n_b.st = cau_pkg::ST_OK;
            end
            cau_pkg::MODE_ADD, cau_pkg::MODE_SUB, cau_pkg::MODE_MUL,
            cau_pkg::MODE_CONJ, cau_pkg::MODE_NEG: begin
                n_b.rr = i_it.rr;
            end
        endcase
    end

    assign out_free = !o_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv     <= 1'b0;
            r_skid_v <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            if (en) r_bv <= i_valid;
            if (out_free) begin
                if (r_skid_v) begin
                    o_valid  <= 1'b1;
                    r_skid_v <= 1'b0;
                end else begin
                    o_valid <= r_bv;
                end
            end else if (r_bv && en) begin
                r_skid_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) r_b <= n_b;
        if (out_free) begin
            r_out <= r_skid_v ? r_skid : r_b;
        end else if (en) begin
            r_skid <= r_b;
        end
    end

    assign o_skid     = r_skid_v;
    assign o_res_real = r_out.rr;
    assign o_res_imag = r_out.ri;
    assign o_status   = r_out.st;

endmodule

// ===== rtl/complex_arith_unit.sv =====
// ----------------------------------------------------------------------------
// complex_arith_unit: pipelined complex arithmetic in signed fixed point
// Add, subtract, multiply, divide, conjugate, negate, magnitude and argument
// of complex operands with FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_valid / o_stall carries i_mode and operands a and b; a
//   transaction completes on a clock edge with i_valid high and o_stall low.
//   Output channel o_valid / i_stall carries res_real, res_imag and status.
//   A scalar operand is given as b with b_imag zero; b is ignored for
//   conjugate, negate, magnitude and argument.
//   Throughput: one transaction per cycle while o_stall is low, for any mix of operations.
//   The pipeline depth is set by the 33 quotient bits of the divider, one
//   per stage; the square root (32 digits) and the CORDIC (CORDIC_STEPS
//   rotations) run alongside in the same stages. Four front stages form
//   products and sums, one back stage formats the result, then the output
//   register.
//   Stall: when the output is held, the next finished result drops into a
//   skid register and o_stall rises in the following cycle; the whole
//   pipeline then holds until the skid entry is taken. Nothing is lost or
//   repeated.
//   Reset (synchronous, active low) clears every valid bit; the data
//   registers are not reset.
// ----------------------------------------------------------------------------
module complex_arith_unit #(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_mode,
    input  logic signed [31:0] i_a_real,
    input  logic signed [31:0] i_a_imag,
    input  logic signed [31:0] i_b_real,
    input  logic signed [31:0] i_b_imag,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_res_real,
    output logic signed [31:0] o_res_imag,
    output logic [1:0]         o_status
);

    // one enable for every stage: advance unless the skid entry is full
    logic         w_skid;
    logic         w_en;
    logic         w_v  [0:cau_pkg::NIT];
    cau_pkg::t_it w_it [0:cau_pkg::NIT];

    assign w_en    = !w_skid;
    assign o_stall = w_skid;

    cau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (i_valid),
        .i_mode   (i_mode),
        .i_a_real (i_a_real),
        .i_a_imag (i_a_imag),
        .i_b_real (i_b_real),
        .i_b_imag (i_b_imag),
        .o_valid  (w_v[0]),
        .o_it     (w_it[0])
    );

    // divider bits, root digits and CORDIC rotations, one stage each
    for (genvar g = 0; g < cau_pkg::NIT; g++) begin : g_iter
        cau_iter #(.STEP(g), .CORDIC_STEPS(CORDIC_STEPS)) u_iter (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_v[g]),
            .i_it    (w_it[g]),
            .o_valid (w_v[g + 1]),
            .o_it    (w_it[g + 1])
        );
    end

    cau_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_v[cau_pkg::NIT]),
        .i_it       (w_it[cau_pkg::NIT]),
        .i_stall    (i_stall),
        .o_skid     (w_skid),
        .o_valid    (o_valid),
        .o_res_real (o_res_real),
        .o_res_imag (o_res_imag),
        .o_status   (o_status)
    );

    // the skid entry fills only behind a held output
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("skid entry full without a pending output");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(o_valid && i_stall))
        else $error("skid entry filled while the output was free");

    // divide by zero always comes with a zero result
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == cau_pkg::ST_DZ) |-> (o_res_real == 32'sd0 &&
        o_res_imag == 32'sd0))
        else $error("divide by zero with a nonzero result");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == cau_pkg::ST_OK || o_status == cau_pkg::ST_DZ ||
        o_status == cau_pkg::ST_SAT))
        else $error("undefined status code");

endmodule
